// ----- rtl/core/cmfd_pkg.sv -----
// ----------------------------------------------------------------------------
// cmfd_pkg
// Shared types, register codes and constants of the motor feedback decoder.
// ----------------------------------------------------------------------------
package cmfd_pkg;

    localparam int ENCODER_MODULUS_DEF = 8192;
    localparam int ACCUM_WIDTH_DEF     = 48;

    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_RX_ID         = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEG_PER_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_LIMIT    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PERSIST_LIMIT = 2'd3;

    localparam logic [10:0] RX_ID_RST         = 11'd518;
    localparam logic [31:0] DEG_PER_COUNT_RST = 32'd188743680;
    localparam logic [7:0]  TEMP_LIMIT_RST    = 8'd80;
    localparam logic [7:0]  PERSIST_LIMIT_RST = 8'd200;

    localparam logic [10:0] GRP_LOW_FIRST  = 11'h201;
    localparam logic [10:0] GRP_LOW_LAST   = 11'h204;
    localparam logic [10:0] GRP_HIGH_FIRST = 11'h205;
    localparam logic [10:0] GRP_HIGH_LAST  = 11'h208;
    localparam logic [10:0] TX_ID_LOW      = 11'h200;
    localparam logic [10:0] TX_ID_HIGH     = 11'h1FF;

    localparam int OUT_W = 48;

    typedef struct packed {
        logic [10:0] rx_id;
        logic [31:0] deg_per_count;
        logic [7:0]  temp_limit;
        logic [7:0]  persist_limit;
    } t_cfg;

    typedef struct packed {
        logic [15:0] encoder;
        logic [15:0] velocity;
        logic [15:0] current;
        logic [7:0]  temperature;
    } t_frame;

    typedef struct packed {
        logic        [15:0]      encoder_raw;
        logic signed [15:0]      speed;
        logic signed [15:0]      torque_current;
        logic        [7:0]       temperature;
        logic signed [OUT_W-1:0] turn_count;
        logic                    over_temperature;
        logic        [10:0]      tx_id;
        logic        [2:0]       slot_index;
    } t_result;

endpackage

// ----- rtl/core/can_motor_feedback_decoder_top.sv -----
// ----------------------------------------------------------------------------
// can_motor_feedback_decoder_top
// Motor feedback frame decoder with multi-turn encoder unwrap and angle.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall): one received frame per word, the
// identifier and seven payload bytes. Frames whose identifier differs from
// rx_id are consumed and give no result.
// Output channel (o_valid / i_stall): one result word per matching frame:
// raw encoder, speed, current, temperature, turn count, Q32.16 angle, the
// sticky over-temperature flag and the latched command group.
// Configuration channel (i_cfg_valid / o_cfg_ready): index and data, always
// ready; write only while no frame is in flight.
// Path: an accepted frame reaches the result through the input register,
// unwrap stage, magnitude stage, product stage and result register.
// Throughput: one frame per cycle unless stalled, set by the five-register
// pipeline with the split 64 by 32 bit angle multiply in its own stage.
// Stall: each stage holds while the one after it is full and blocked; the
// input stalls only once every stage holds a word.
// Reset: clears control state, configuration to defaults, empties the pipe.
// ----------------------------------------------------------------------------
module can_motor_feedback_decoder_top #(
    parameter int ENCODER_MODULUS = cmfd_pkg::ENCODER_MODULUS_DEF,
    parameter int ACCUM_WIDTH     = cmfd_pkg::ACCUM_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [10:0]                      i_frame_id,
    input  logic [7:0]                       i_byte0,
    input  logic [7:0]                       i_byte1,
    input  logic [7:0]                       i_byte2,
    input  logic [7:0]                       i_byte3,
    input  logic [7:0]                       i_byte4,
    input  logic [7:0]                       i_byte5,
    input  logic [7:0]                       i_byte6,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [15:0]                      o_encoder_raw,
    output logic signed [15:0]               o_speed,
    output logic signed [15:0]               o_torque_current,
    output logic [7:0]                       o_temperature,
    output logic signed [47:0]               o_turn_count,
    output logic signed [47:0]               o_angle_q16,
    output logic                             o_over_temperature,
    output logic [10:0]                      o_tx_id,
    output logic [2:0]                       o_slot_index,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cmfd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [31:0]                      i_cfg_data
);
    import cmfd_pkg::*;

    t_cfg                          r_cfg;
    logic                          r_in_valid;
    logic [10:0]                   r_in_id;
    t_frame                        r_in_frame;

    logic                          match, take1, take_in;
    logic                          u_valid, a_take;
    t_result                       u_result, a_result;
    logic signed [ACCUM_WIDTH-1:0] u_count;
    logic signed [47:0]            a_angle;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rx_id         <= RX_ID_RST;
            r_cfg.deg_per_count <= DEG_PER_COUNT_RST;
            r_cfg.temp_limit    <= TEMP_LIMIT_RST;
            r_cfg.persist_limit <= PERSIST_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_RX_ID:         r_cfg.rx_id         <= i_cfg_data[10:0];
                REG_DEG_PER_COUNT: r_cfg.deg_per_count <= i_cfg_data;
                REG_TEMP_LIMIT:    r_cfg.temp_limit    <= i_cfg_data[7:0];
                REG_PERSIST_LIMIT: r_cfg.persist_limit <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // input register, non-matching words are dropped here
    assign match   = (r_in_id == r_cfg.rx_id);
    assign take_in = !r_in_valid || !match || take1;
    assign o_stall = !take_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take_in) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && take_in) begin
            r_in_id                <= i_frame_id;
            r_in_frame.encoder     <= {i_byte0, i_byte1};
            r_in_frame.velocity    <= {i_byte2, i_byte3};
            r_in_frame.current     <= {i_byte4, i_byte5};
            r_in_frame.temperature <= i_byte6;
        end
    end

    cmfd_unwrap #(
        .ENCODER_MODULUS (ENCODER_MODULUS),
        .ACCUM_WIDTH     (ACCUM_WIDTH)
    ) u_unwrap (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid && match),
        .o_take   (take1),
        .i_cfg    (r_cfg),
        .i_frame  (r_in_frame),
        .o_valid  (u_valid),
        .o_result (u_result),
        .o_count  (u_count),
        .i_take   (a_take)
    );

    cmfd_angle #(
        .ACCUM_WIDTH (ACCUM_WIDTH)
    ) u_angle (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (u_valid),
        .o_take          (a_take),
        .i_result        (u_result),
        .i_count         (u_count),
        .i_deg_per_count (r_cfg.deg_per_count),
        .o_valid         (o_valid),
        .o_result        (a_result),
        .o_angle         (a_angle),
        .i_stall         (i_stall)
    );

    assign o_encoder_raw      = a_result.encoder_raw;
    assign o_speed            = a_result.speed;
    assign o_torque_current   = a_result.torque_current;
    assign o_temperature      = a_result.temperature;
    assign o_turn_count       = a_result.turn_count;
    assign o_angle_q16        = a_angle;
    assign o_over_temperature = a_result.over_temperature;
    assign o_tx_id            = a_result.tx_id;
    assign o_slot_index       = a_result.slot_index;

    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_stall)
        else $error("input stalled with an empty input register");

    a_stall_needs_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while the output side can move");

endmodule

// ----- rtl/core/cmfd_unwrap.sv -----
// ----------------------------------------------------------------------------
// cmfd_unwrap
// Decode stage: encoder unwrap into the saturating count, over-temperature
// tracking and first-frame command group latch.
// ----------------------------------------------------------------------------
module cmfd_unwrap #(
    parameter int ENCODER_MODULUS = cmfd_pkg::ENCODER_MODULUS_DEF,
    parameter int ACCUM_WIDTH     = cmfd_pkg::ACCUM_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_take,
    input  cmfd_pkg::t_cfg                i_cfg,
    input  cmfd_pkg::t_frame              i_frame,
    output logic                          o_valid,
    output cmfd_pkg::t_result             o_result,
    output logic signed [ACCUM_WIDTH-1:0] o_count,
    input  logic                          i_take
);
    import cmfd_pkg::*;

    localparam logic signed [17:0] ModS = 18'(ENCODER_MODULUS);
    localparam logic signed [ACCUM_WIDTH-1:0] AccMax = {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
    localparam logic signed [ACCUM_WIDTH-1:0] AccMin = {1'b1, {(ACCUM_WIDTH-1){1'b0}}};

    logic                          r_started, n_started;
    logic [15:0]                   r_prev, n_prev;
    logic signed [ACCUM_WIDTH-1:0] r_acc, n_acc;
    logic [7:0]                    r_hot, n_hot;
    logic                          r_fault, n_fault;
    logic [10:0]                   r_tx, n_tx;
    logic [2:0]                    r_slot, n_slot;

    logic                          r_valid;
    t_result                       r_result;
    logic signed [ACCUM_WIDTH-1:0] r_count;

    logic                          load;
    logic [7:0]                    hot_inc;
    logic [10:0]                   grp_off;
    logic [15:0]                   prev_eff;
    logic signed [ACCUM_WIDTH-1:0] acc_eff;
    logic signed [17:0]            direct, wrapped, abs_d, abs_w, step;
    logic signed [ACCUM_WIDTH:0]   sum;

    assign o_take = !r_valid || i_take;
    assign load   = i_valid && o_take;

    always_comb begin
        n_started = r_started;
        n_prev    = r_prev;
        n_acc     = r_acc;
        n_hot     = r_hot;
        n_fault   = r_fault;
        n_tx      = r_tx;
        n_slot    = r_slot;
        grp_off   = 11'd0;

        // temperature persistence
        hot_inc = (r_hot == 8'hFF) ? r_hot : r_hot + 8'd1;
        if (i_frame.temperature > i_cfg.temp_limit) begin
            if (hot_inc > i_cfg.persist_limit) begin
                n_fault = 1'b1;
                n_hot   = 8'd0;
            end else begin
                n_hot = hot_inc;
            end
        end else begin
            n_hot = 8'd0;
        end

        // command group latch on the first frame
        if (!r_started) begin
            if (i_cfg.rx_id inside {[GRP_HIGH_FIRST:GRP_HIGH_LAST]}) begin
                grp_off = i_cfg.rx_id - GRP_HIGH_FIRST;
                n_tx    = TX_ID_HIGH;
                n_slot  = {grp_off[1:0], 1'b0};
            end else if (i_cfg.rx_id inside {[GRP_LOW_FIRST:GRP_LOW_LAST]}) begin
                grp_off = i_cfg.rx_id - GRP_LOW_FIRST;
                n_tx    = TX_ID_LOW;
                n_slot  = {grp_off[1:0], 1'b0};
            end
        end

        // unwrap by the shorter distance
        prev_eff = r_started ? r_prev : i_frame.encoder;
        acc_eff  = r_started ? r_acc : '0;
        direct   = $signed({2'b00, i_frame.encoder}) - $signed({2'b00, prev_eff});
        if (direct < 0) begin
            wrapped = direct + ModS;
        end else if (direct > 0) begin
            wrapped = direct - ModS;
        end else begin
            wrapped = '0;
        end
        abs_d = (direct < 0) ? -direct : direct;
        abs_w = (wrapped < 0) ? -wrapped : wrapped;
        step  = (abs_w > abs_d) ? direct : wrapped;

        sum = {acc_eff[ACCUM_WIDTH-1], acc_eff} + (ACCUM_WIDTH+1)'(step);
        if (sum[ACCUM_WIDTH] != sum[ACCUM_WIDTH-1]) begin
            n_acc = sum[ACCUM_WIDTH] ? AccMin : AccMax;
        end else begin
            n_acc = sum[ACCUM_WIDTH-1:0];
        end

        n_prev    = i_frame.encoder;
        n_started = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_prev    <= '0;
            r_acc     <= '0;
            r_hot     <= '0;
            r_fault   <= 1'b0;
            r_tx      <= '0;
            r_slot    <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (load) begin
                r_started <= n_started;
                r_prev    <= n_prev;
                r_acc     <= n_acc;
                r_hot     <= n_hot;
                r_fault   <= n_fault;
                r_tx      <= n_tx;
                r_slot    <= n_slot;
                r_valid   <= 1'b1;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result.encoder_raw      <= i_frame.encoder;
            r_result.speed            <= $signed(i_frame.velocity);
            r_result.torque_current   <= $signed(i_frame.current);
            r_result.temperature      <= i_frame.temperature;
            r_result.turn_count       <= OUT_W'(64'(n_acc));
            r_result.over_temperature <= n_fault;
            r_result.tx_id            <= n_tx;
            r_result.slot_index       <= n_slot;
            r_count                   <= n_acc;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_count  = r_count;

    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault |=> r_fault)
        else $error("over-temperature flag cleared without reset");

    a_slot_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_slot[0] && r_slot <= 3'd6)
        else $error("slot index not an even byte offset");

    a_group_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started && !load |=> $stable(r_tx) && $stable(r_slot))
        else $error("command group changed without a frame");

endmodule

// ----- rtl/core/cmfd_angle.sv -----
// ----------------------------------------------------------------------------
// cmfd_angle
// Angle pipeline: magnitude, split multiply by the scale, rounding and
// saturation into the Q32.16 result register.
// ----------------------------------------------------------------------------
module cmfd_angle #(
    parameter int ACCUM_WIDTH = cmfd_pkg::ACCUM_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_take,
    input  cmfd_pkg::t_result             i_result,
    input  logic signed [ACCUM_WIDTH-1:0] i_count,
    input  logic [31:0]                   i_deg_per_count,
    output logic                          o_valid,
    output cmfd_pkg::t_result             o_result,
    output logic signed [47:0]            o_angle,
    input  logic                          i_stall
);
    import cmfd_pkg::*;

    localparam logic [48:0] LimPos = {2'b00, {47{1'b1}}};
    localparam logic [48:0] LimNeg = {2'b01, {47{1'b0}}};

    // magnitude stage
    logic                   r_v2;
    t_result                r_res2;
    logic                   r_neg2;
    logic [63:0]            r_mag2;
    // product stage
    logic                   r_v3;
    t_result                r_res3;
    logic                   r_neg3;
    logic [63:0]            r_lo3, r_hi3;
    // result stage
    logic                   r_v4;
    t_result                r_res4;
    logic                   r_neg4;
    logic signed [47:0]     r_angle4;

    logic                   take4, take3, take2;
    logic                   load4, load3, load2;
    logic [ACCUM_WIDTH-1:0] mag;
    logic [48:0]            q, lim;
    logic [47:0]            q_sat;
    logic                   ovf;
    logic signed [47:0]     n_angle;

    assign take4  = !r_v4 || !i_stall;
    assign take3  = !r_v3 || take4;
    assign take2  = !r_v2 || take3;
    assign load4  = r_v3 && take4;
    assign load3  = r_v2 && take3;
    assign load2  = i_valid && take2;
    assign o_take = take2;

    assign mag = i_count[ACCUM_WIDTH-1] ? ACCUM_WIDTH'(-i_count) : ACCUM_WIDTH'(i_count);

    always_comb begin
        ovf   = |r_hi3[63:32];
        q     = {1'b0, r_hi3[31:0], 16'h0000} + {1'b0, r_lo3[63:16]} + 49'(r_lo3[15]);
        lim   = r_neg3 ? LimNeg : LimPos;
        q_sat = (ovf || q > lim) ? lim[47:0] : q[47:0];
        n_angle = r_neg3 ? $signed(-q_sat) : $signed(q_sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (take2) begin
                r_v2 <= i_valid;
            end
            if (take3) begin
                r_v3 <= r_v2;
            end
            if (take4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load2) begin
            r_res2 <= i_result;
            r_neg2 <= i_count[ACCUM_WIDTH-1];
            r_mag2 <= 64'(mag);
        end
        if (load3) begin
            r_res3 <= r_res2;
            r_neg3 <= r_neg2;
            r_lo3  <= r_mag2[31:0] * i_deg_per_count;
            r_hi3  <= r_mag2[63:32] * i_deg_per_count;
        end
        if (load4) begin
            r_res4   <= r_res3;
            r_neg4   <= r_neg3;
            r_angle4 <= n_angle;
        end
    end

    assign o_valid  = r_v4;
    assign o_result = r_res4;
    assign o_angle  = r_angle4;

    a_angle_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && !r_neg4 |-> !r_angle4[47])
        else $error("angle of a non-negative count came out negative");

endmodule
